// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file trm_checker.sv
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define TRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// next-cycle implication, disabled while reset is held
`define TRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ----- hdl/trm_pkg.sv -----
// shared types, opcodes and result codes of the register machine step block
// no dependencies
`timescale 1ns / 1ps

package trm_pkg;

  localparam int NUM_REGS   = 32;
  localparam int REG_AW     = $clog2(NUM_REGS);
  localparam int PROG_DEPTH = 1024;
  localparam int PC_W       = 11;
  localparam int DATA_W     = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADDI = 4'd1,
    OP_SUB  = 4'd2,
    OP_SUBI = 4'd3,
    OP_MUL  = 4'd4,
    OP_MULI = 4'd5,
    OP_DIV  = 4'd6,
    OP_DIVI = 4'd7,
    OP_BZ   = 4'd8,
    OP_BP   = 4'd9,
    OP_BN   = 4'd10,
    OP_IN   = 4'd11,
    OP_OUT  = 4'd12,
    OP_OUTC = 4'd13
  } op_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_BAD_OP   = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO = 2'd3;

  typedef struct packed {
    logic [3:0]               op;
    logic [4:0]               dest_reg;
    logic [4:0]               src1_reg;
    logic [4:0]               src2_reg;
    logic signed [DATA_W-1:0] immediate;
    logic [PC_W-1:0]          branch_target;
    logic [7:0]               char_code;
    logic signed [DATA_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic [1:0]               out_kind;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

// ----- hdl/trm_regfile.sv -----
// register file memory: two registered read ports, one write port
// per-entry valid bits make never-written registers read as zero; uses trm_pkg
`timescale 1ns / 1ps

module trm_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [trm_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [trm_pkg::REG_AW-1:0] rd_addr_b,
  output logic [trm_pkg::DATA_W-1:0] rd_data_a,
  output logic [trm_pkg::DATA_W-1:0] rd_data_b,
  input  trm_pkg::rf_wr_t           wr
);
  import trm_pkg::*;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [DATA_W-1:0]   data_a_r;
  logic [DATA_W-1:0]   data_b_r;
  logic                va_r;
  logic                vb_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      data_a_r <= mem[rd_addr_a];
      data_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        va_r <= vld_r[rd_addr_a];
        vb_r <= vld_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = va_r ? data_a_r : '0;
  assign rd_data_b = vb_r ? data_b_r : '0;

endmodule

// ----- hdl/trm_div.sv -----
// radix-2 restoring divider for signed 32-bit operands, truncating toward zero
// one quotient bit per cycle, then a sign fix step; uses trm_pkg
`timescale 1ns / 1ps

module trm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [trm_pkg::DATA_W-1:0] dividend,
  input  logic [trm_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [trm_pkg::DATA_W-1:0] quotient
);
  import trm_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t           state_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic              done_r;
  logic [DATA_W-1:0] q_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= '0;
            quo_r   <= dividend[DATA_W-1] ? (DATA_W)'(0 - dividend) : dividend;
            dvs_r   <= divisor[DATA_W-1] ? (DATA_W)'(0 - divisor) : divisor;
            neg_r   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            cnt_r   <= CNT_W'(DATA_W);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (!diff[DATA_W]) begin
            rem_r <= diff[DATA_W-1:0];
            quo_r <= {quo_r[DATA_W-2:0], 1'b1};
          end else begin
            rem_r <= shifted[DATA_W-1:0];
            quo_r <= {quo_r[DATA_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          q_r     <= neg_r ? (DATA_W)'(0 - quo_r) : quo_r;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- hdl/toy_register_machine_step_top.sv -----
// top level of the register machine step block: sequencer, result register
// depends on trm_pkg, trm_regfile and trm_div
//
// Usage: each input transaction on in_valid/in_ready carries the instruction at
// the current program counter plus the value an IN instruction would read.
// Exactly one result transaction on out_valid/out_ready follows for each one,
// holding the new program counter, any OUT/OUTC output and a status code.
// cfg_wr_en/cfg_wr_data write program_length at any edge with no wait; write
// it only while no transaction is in flight.
// Each instruction passes through the instruction register and the registered
// register file reads, then the result register, then the output register that
// drives out_valid. DIV/DIVI with a nonzero divisor first run the radix-2
// divider (one quotient bit per cycle plus a sign fix step). One instruction is
// in flight at a time, so a new transaction is accepted only once the last
// result has moved to the output register.
// A finished result waits in the output register while the next instruction is
// accepted; if the receiver stalls, the sequencer holds its result until the
// output register frees up. Reset clears the registers (all read as zero), the
// program counter, the halted flag and program_length; no clearing pass.
`timescale 1ns / 1ps

module toy_register_machine_step_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  trm_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output trm_pkg::out_item_t       out_data,
  input  logic                     cfg_wr_en,
  input  logic [trm_pkg::PC_W-1:0] cfg_wr_data
);
  import trm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_OPER, S_DIV, S_FIN} state_t;

  state_t            state_r, state_nxt;
  in_item_t          ins_r;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r;
  logic              out_valid_r;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              halted_r, halted_nxt;
  logic [PC_W-1:0]   plen_r;

  logic              rd_en;
  logic [REG_AW-1:0] rd_addr_a;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  rf_wr_t            rf_wr;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  logic [PC_W-1:0]   len_eff;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] mul_lo;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign rd_en     = in_valid && in_ready;
  assign rd_addr_a = (in_data.op == OP_OUT) ? in_data.dest_reg[REG_AW-1:0]
                                            : in_data.src1_reg[REG_AW-1:0];

  trm_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (in_data.src2_reg[REG_AW-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr        (rf_wr)
  );

  trm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_q)
  );

  assign len_eff  = (plen_r > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : plen_r;
  assign opa      = rd_a;
  assign opb      = ins_r.op[0] ? ins_r.immediate : rd_b;
  assign mul_lo   = opa * opb;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    logic              fin;
    logic [PC_W-1:0]   npc;
    logic [1:0]        kind;
    logic [DATA_W-1:0] oval;
    logic [1:0]        st;
    logic              brk;

    state_nxt  = state_r;
    res_nxt    = res_r;
    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    rf_wr      = '0;
    div_start  = 1'b0;
    fin        = 1'b0;
    npc        = pc_r + 1'b1;
    kind       = KIND_NONE;
    oval       = '0;
    st         = ST_RUNNING;
    brk        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (rd_en) begin
          state_nxt = S_OPER;
        end
      end
      S_OPER: begin
        if (halted_r || pc_r >= len_eff) begin
          // nothing runs; report the counter as finished
          res_nxt   = '{next_pc: pc_r, out_kind: KIND_NONE, out_value: '0,
                        status: ST_FINISHED};
          state_nxt = S_FIN;
        end else begin
          fin        = 1'b1;
          rf_wr.addr = ins_r.dest_reg[REG_AW-1:0];
          unique case (ins_r.op) inside
            OP_ADD, OP_ADDI: begin
              rf_wr.en   = 1'b1;
              rf_wr.data = opa + opb;
            end
            OP_SUB, OP_SUBI: begin
              rf_wr.en   = 1'b1;
              rf_wr.data = opa - opb;
            end
            OP_MUL, OP_MULI: begin
              rf_wr.en   = 1'b1;
              rf_wr.data = mul_lo;
            end
            OP_DIV, OP_DIVI: begin
              if (opb == '0) begin
                halted_nxt = 1'b1;
                npc        = pc_r;
                st         = ST_DIV_ZERO;
              end else begin
                fin       = 1'b0;
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_BZ: brk = (opa == '0);
            OP_BP: brk = (opa != '0) && !opa[DATA_W-1];
            OP_BN: brk = opa[DATA_W-1];
            OP_IN: begin
              rf_wr.en   = 1'b1;
              rf_wr.data = ins_r.in_value;
            end
            OP_OUT: begin
              kind = KIND_NUM;
              oval = opa;
            end
            OP_OUTC: begin
              kind = KIND_CHAR;
              oval = {{(DATA_W-8){1'b0}}, ins_r.char_code};
            end
            default: begin
              halted_nxt = 1'b1;
              npc        = pc_r;
              st         = ST_BAD_OP;
            end
          endcase
          if (brk) begin
            // 1-based line to zero-based counter, wraps for target zero
            npc = ins_r.branch_target - 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          fin        = 1'b1;
          rf_wr.en   = 1'b1;
          rf_wr.addr = ins_r.dest_reg[REG_AW-1:0];
          rf_wr.data = div_q;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      if (st == ST_RUNNING && npc >= len_eff) begin
        st = ST_FINISHED;
      end
      pc_nxt    = npc;
      res_nxt   = '{next_pc: npc, out_kind: kind, out_value: oval, status: st};
      state_nxt = S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      plen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      halted_r <= halted_nxt;
      if (cfg_wr_en) begin
        plen_r <= cfg_wr_data;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ins_r <= in_data;
    end
    res_r <= res_nxt;
    if (state_r == S_FIN && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/trm_checker.sv -----
// port-level checks of the register machine step block, bound to the top level
// depends on trm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input trm_pkg::out_item_t  out_data
);
  import trm_pkg::*;

  // a stalled result stays offered
  `TRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one instruction in flight: no transaction right after an accepted one
  `TRM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // a halting result never carries output
  `TRM_ASSERT_SAME(a_halt_no_out, clk, rst_n,
    out_valid && (out_data.status == ST_BAD_OP || out_data.status == ST_DIV_ZERO),
    out_data.out_kind == KIND_NONE)

  // no output means a zero value and a known kind
  `TRM_ASSERT_SAME(a_quiet_zero, clk, rst_n,
    out_valid && out_data.out_kind != KIND_NUM && out_data.out_kind != KIND_CHAR,
    out_data.out_kind == KIND_NONE && out_data.out_value == '0)

endmodule

bind toy_register_machine_step_top trm_checker u_trm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
